// ===== rtl/core/ffr_pkg.sv =====
// ----------------------------------------------------------------------------
// ffr_pkg
// shared types and constants of the fixed frame receiver
// ----------------------------------------------------------------------------
package ffr_pkg;

	localparam int unsigned PaddrWidth = 3;

	localparam logic [3:0] DataLastPos  = 4'd7;
	localparam logic [3:0] CheckPos     = 4'd8;
	localparam logic [3:0] FrameLastPos = 4'd9;

	localparam logic [7:0] StartMarkerReset = 8'd170;
	localparam logic [7:0] EndMarkerReset   = 8'd85;

	typedef enum logic [1:0] {
		ST_NONE    = 2'd0,
		ST_OK      = 2'd1,
		ST_BAD_END = 2'd2,
		ST_BAD_SUM = 2'd3
	} ffr_status_t;

	typedef enum logic {
		CFG_START_MARKER = 1'b0,
		CFG_END_MARKER   = 1'b1
	} ffr_cfg_idx_t;

	typedef struct packed {
		logic [7:0] start_marker;
		logic [7:0] end_marker;
	} ffr_cfg_t;

	typedef struct packed {
		ffr_status_t status;
		logic [7:0]  msg_id;
		logic [15:0] left_drive;
		logic [15:0] right_drive;
		logic [15:0] steer_drive;
	} ffr_result_t;

endpackage

// ===== rtl/core/ffr_if.sv =====
// ----------------------------------------------------------------------------
// ffr channel interfaces
// valid/ready channels for received bytes and frame status words
// ----------------------------------------------------------------------------
interface ffr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface ffr_status_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_status;
	logic [7:0]  msg_id;
	logic [15:0] left_drive;
	logic [15:0] right_drive;
	logic [15:0] steer_drive;

	modport source (
		output valid, output frame_status, output msg_id,
		output left_drive, output right_drive, output steer_drive,
		input ready
	);
	modport sink (
		input valid, input frame_status, input msg_id,
		input left_drive, input right_drive, input steer_drive,
		output ready
	);
endinterface

// ===== rtl/core/fixed_frame_receiver_core.sv =====
// ----------------------------------------------------------------------------
// fixed_frame_receiver_core
// 10-byte frame receiver with xor checksum, one status word per byte
//
//   channel  dir  payload                                     handshake
//   rx       in   rx_byte                                     valid/ready
//   status   out  frame_status, msg_id, left/right/steer      valid/ready
//   apb      in   start_marker (0x0), end_marker (0x4)        psel/penable
//
// one byte per cycle sustained while status words are taken; a status word
// passes through the input register, then the result register
// reset clears frame tracking and loads the marker defaults
// a stalled status word holds; one more byte is still taken into the
// input register before rx ready drops
// ----------------------------------------------------------------------------
module fixed_frame_receiver_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ffr_pkg::PaddrWidth-1:0]  paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	ffr_byte_if.sink                        rx,
	ffr_status_if.source                    status
);

	ffr_pkg::ffr_cfg_t    cfg;
	ffr_pkg::ffr_result_t result;
	ffr_pkg::ffr_result_t out_q;
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 out_valid_q;
	logic                 out_free;
	logic                 advance;

	ffr_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign out_free = !out_valid_q || status.ready;
	assign advance  = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	ffr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (status.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign status.valid        = out_valid_q;
	assign status.frame_status = out_q.status;
	assign status.msg_id       = out_q.msg_id;
	assign status.left_drive   = out_q.left_drive;
	assign status.right_drive  = out_q.right_drive;
	assign status.steer_drive  = out_q.steer_drive;

endmodule

// ===== rtl/core/ffr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ffr_cfg_regs
// apb register block holding the start and end marker bytes
// ----------------------------------------------------------------------------
module ffr_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ffr_pkg::PaddrWidth-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output ffr_pkg::ffr_cfg_t                cfg
);

	ffr_pkg::ffr_cfg_idx_t reg_idx;
	logic                  wr_en;
	logic [7:0]            start_marker_q;
	logic [7:0]            end_marker_q;

	assign pready  = 1'b1;
	assign reg_idx = ffr_pkg::ffr_cfg_idx_t'(paddr[2]);
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q <= ffr_pkg::StartMarkerReset;
			end_marker_q   <= ffr_pkg::EndMarkerReset;
		end else if (wr_en) begin
			unique case (reg_idx)
				ffr_pkg::CFG_START_MARKER: start_marker_q <= pwdata[7:0];
				ffr_pkg::CFG_END_MARKER:   end_marker_q   <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			ffr_pkg::CFG_START_MARKER: prdata = {24'd0, start_marker_q};
			ffr_pkg::CFG_END_MARKER:   prdata = {24'd0, end_marker_q};
			default:                   prdata = '0;
		endcase
	end

	assign cfg.start_marker = start_marker_q;
	assign cfg.end_marker   = end_marker_q;

endmodule

// ===== rtl/core/ffr_parser.sv =====
// ----------------------------------------------------------------------------
// ffr_parser
// frame tracking state, running xor and per-byte status decision
// ----------------------------------------------------------------------------
module ffr_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	input  ffr_pkg::ffr_cfg_t     cfg,
	output ffr_pkg::ffr_result_t  result
);

	logic       collecting_q;
	logic       collecting_d;
	logic [3:0] pos_q;
	logic [3:0] pos_d;
	logic [7:0] xor_q;
	logic [7:0] xor_d;
	logic [7:0] check_q;
	logic       check_wr;
	logic       data_wr;
	logic [7:0] data_q [1:7];

	always_comb begin
		collecting_d = collecting_q;
		pos_d        = pos_q;
		xor_d        = xor_q;
		check_wr     = 1'b0;
		data_wr      = 1'b0;
		result       = '0;
		result.status = ffr_pkg::ST_NONE;
		if (!collecting_q) begin
			if (rx_byte == cfg.start_marker) begin
				collecting_d = 1'b1;
				pos_d        = 4'd1;
				xor_d        = 8'd0;
			end
		end else if (pos_q == 4'd0 || pos_q > ffr_pkg::FrameLastPos) begin
			collecting_d = 1'b0;
			pos_d        = 4'd0;
		end else if (pos_q < ffr_pkg::FrameLastPos) begin
			pos_d = pos_q + 4'd1;
			if (pos_q <= ffr_pkg::DataLastPos) begin
				data_wr = 1'b1;
				xor_d   = xor_q ^ rx_byte;
			end else begin
				check_wr = 1'b1;
			end
		end else begin
			collecting_d = 1'b0;
			pos_d        = 4'd0;
			if (rx_byte != cfg.end_marker) begin
				result.status = ffr_pkg::ST_BAD_END;
			end else if (check_q != xor_q) begin
				result.status = ffr_pkg::ST_BAD_SUM;
			end else begin
				result.status      = ffr_pkg::ST_OK;
				result.msg_id      = data_q[1];
				result.left_drive  = {data_q[3], data_q[2]};
				result.right_drive = {data_q[5], data_q[4]};
				result.steer_drive = {data_q[7], data_q[6]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			collecting_q <= 1'b0;
			pos_q        <= 4'd0;
		end else if (step) begin
			collecting_q <= collecting_d;
			pos_q        <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			xor_q <= xor_d;
			if (check_wr) begin
				check_q <= rx_byte;
			end
			if (data_wr) begin
				data_q[pos_q[2:0]] <= rx_byte;
			end
		end
	end

endmodule
